[src/udp_payload_signature_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// udp_payload_signature_filter_unit_assert.svh
// Assertion macros shared by the UDP payload signature filter RTL.
// ----------------------------------------------------------------------------
`ifndef UDP_PAYLOAD_SIGNATURE_FILTER_UNIT_ASSERT_SVH
`define UDP_PAYLOAD_SIGNATURE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define UPF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/upf_pkg.sv]
// ----------------------------------------------------------------------------
// upf_pkg
// Shared types, verdict codes, frame offsets and the payload signature table.
// ----------------------------------------------------------------------------
package upf_pkg;

  // Verdict reason codes
  localparam logic [2:0] REASON_NONE      = 3'd0;
  localparam logic [2:0] REASON_PASSED    = 3'd1;
  localparam logic [2:0] REASON_TOO_SMALL = 3'd2;
  localparam logic [2:0] REASON_TOO_LARGE = 3'd3;
  localparam logic [2:0] REASON_FRAGMENT  = 3'd4;
  localparam logic [2:0] REASON_SIGNATURE = 3'd5;

  // Register indexes
  localparam logic REG_DEST_PORT   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam logic [15:0] DEST_PORT_RESET   = 16'd40000;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;

  // Fixed header offsets (20-byte IPv4 header assumed)
  localparam int OFS_ETHERTYPE_HI = 12;
  localparam int OFS_ETHERTYPE_LO = 13;
  localparam int OFS_FRAG_HI      = 20;
  localparam int OFS_FRAG_LO      = 21;
  localparam int OFS_PROTOCOL     = 23;
  localparam int OFS_PORT_HI      = 36;
  localparam int OFS_PORT_LO      = 37;
  localparam int OFS_PAYLOAD      = 42;
  localparam int MIN_PAYLOAD      = 16;

  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  // Flags byte with the don't-fragment bit masked off
  localparam logic [7:0] FRAG_HI_MASK = 8'hBF;

  typedef struct packed {
    logic [15:0] dest_port;
    logic [15:0] max_payload_bytes;
  } upf_cfg_t;

  typedef struct packed {
    logic       pass_frame;
    logic [2:0] verdict_reason;
  } upf_verdict_t;

  // Signature check of payload byte k; unchecked indices pass
  function automatic logic sig_byte_ok(input logic [3:0] k, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    unique case (k)
      4'd1:    ok = (b >= 8'h2A) && (b <= 8'h2D);
      4'd2:    ok = (b >= 8'hC8) && (b <= 8'hE7);
      4'd3:    ok = (b >= 8'h05) && (b <= 8'h44);
      4'd5:    ok = (b >= 8'h4E) && (b <= 8'h51);
      4'd6:    ok = (b >= 8'h60) && (b <= 8'hDF);
      4'd7:    ok = (b >= 8'h64) && (b <= 8'hE3);
      4'd8:    ok = (b == 8'h07) || (b == 8'h4F);
      4'd9:    ok = (b == 8'h25) || (b == 8'h53);
      4'd10:   ok = (b >= 8'h7C) && (b <= 8'h83);
      4'd11:   ok = (b >= 8'hAF) && (b <= 8'hB6);
      4'd12:   ok = (b >= 8'h21) && (b <= 8'h60);
      4'd13:   ok = (b == 8'h61) || (b == 8'h05) || (b == 8'h2B) || (b == 8'h0D);
      4'd14:   ok = (b >= 8'hD2) && (b <= 8'hF1);
      4'd15:   ok = (b >= 8'h11) && (b <= 8'h90);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

[src/upf_in_if.sv]
// ----------------------------------------------------------------------------
// upf_in_if
// Frame byte channel: valid/ready handshake with one byte and end marker.
// ----------------------------------------------------------------------------
interface upf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

[src/upf_out_if.sv]
// ----------------------------------------------------------------------------
// upf_out_if
// Verdict channel: valid/ready handshake with pass flag and reason code.
// ----------------------------------------------------------------------------
interface upf_out_if;
  logic       valid;
  logic       ready;
  logic       pass_frame;
  logic [2:0] verdict_reason;

  modport source (output valid, output pass_frame, output verdict_reason, input ready);
  modport sink   (input valid, input pass_frame, input verdict_reason, output ready);
endinterface

[src/upf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// upf_cfg_regs
// APB-style register file holding the inspected port and payload limit.
// ----------------------------------------------------------------------------
module upf_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output upf_pkg::upf_cfg_t cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_port         <= upf_pkg::DEST_PORT_RESET;
      cfg.max_payload_bytes <= upf_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        upf_pkg::REG_DEST_PORT:   cfg.dest_port         <= pwdata[15:0];
        upf_pkg::REG_MAX_PAYLOAD: cfg.max_payload_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      upf_pkg::REG_DEST_PORT:   prdata = {16'd0, cfg.dest_port};
      upf_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, cfg.max_payload_bytes};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

[src/upf_inspect.sv]
// ----------------------------------------------------------------------------
// upf_inspect
// Per-frame header/payload checks and the verdict for the current byte.
// ----------------------------------------------------------------------------
module upf_inspect #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            frame_byte,
  input  logic                  last_byte,
  input  upf_pkg::upf_cfg_t     cfg,
  output upf_pkg::upf_verdict_t verdict
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] POS_ETH_HI  = COUNT_BITS'(upf_pkg::OFS_ETHERTYPE_HI);
  localparam logic [COUNT_BITS-1:0] POS_ETH_LO  = COUNT_BITS'(upf_pkg::OFS_ETHERTYPE_LO);
  localparam logic [COUNT_BITS-1:0] POS_FRAG_HI = COUNT_BITS'(upf_pkg::OFS_FRAG_HI);
  localparam logic [COUNT_BITS-1:0] POS_FRAG_LO = COUNT_BITS'(upf_pkg::OFS_FRAG_LO);
  localparam logic [COUNT_BITS-1:0] POS_PROTO   = COUNT_BITS'(upf_pkg::OFS_PROTOCOL);
  localparam logic [COUNT_BITS-1:0] POS_PORT_HI = COUNT_BITS'(upf_pkg::OFS_PORT_HI);
  localparam logic [COUNT_BITS-1:0] POS_PORT_LO = COUNT_BITS'(upf_pkg::OFS_PORT_LO);
  localparam logic [COUNT_BITS-1:0] POS_PAYLOAD = COUNT_BITS'(upf_pkg::OFS_PAYLOAD);
  localparam logic [COUNT_BITS-1:0] POS_PAY_END =
    COUNT_BITS'(upf_pkg::OFS_PAYLOAD + upf_pkg::MIN_PAYLOAD);

  // Frame state
  logic [COUNT_BITS-1:0] byte_count;
  logic                  ethertype_ok;
  logic                  udp_protocol_ok;
  logic                  port_match;
  logic                  fragment_seen;
  logic                  signature_ok;

  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] payload_len;
  logic [3:0]            sig_index;
  logic                  eth_fail, frag_hit, udp_fail, port_fail, sig_fail;
  logic                  ethertype_ok_next, udp_protocol_ok_next, port_match_next;
  logic                  fragment_seen_next, signature_ok_next;
  logic                  inspected;

  // Field checks at fixed offsets
  always_comb begin
    eth_fail  = ((byte_count == POS_ETH_HI) && (frame_byte != upf_pkg::ETHERTYPE_HI)) ||
                ((byte_count == POS_ETH_LO) && (frame_byte != upf_pkg::ETHERTYPE_LO));
    frag_hit  = ((byte_count == POS_FRAG_HI) &&
                 ((frame_byte & upf_pkg::FRAG_HI_MASK) != 8'd0)) ||
                ((byte_count == POS_FRAG_LO) && (frame_byte != 8'd0));
    udp_fail  = (byte_count == POS_PROTO) && (frame_byte != upf_pkg::PROTO_UDP);
    port_fail = ((byte_count == POS_PORT_HI) && (frame_byte != cfg.dest_port[15:8])) ||
                ((byte_count == POS_PORT_LO) && (frame_byte != cfg.dest_port[7:0]));
    sig_index = 4'(byte_count - POS_PAYLOAD);
    sig_fail  = (byte_count > POS_PAYLOAD) && (byte_count < POS_PAY_END) &&
                !upf_pkg::sig_byte_ok(sig_index, frame_byte);

    ethertype_ok_next    = ethertype_ok && !eth_fail;
    udp_protocol_ok_next = udp_protocol_ok && !udp_fail;
    port_match_next      = port_match && !port_fail;
    fragment_seen_next   = fragment_seen || frag_hit;
    signature_ok_next    = signature_ok && !sig_fail;
  end

  // Saturating length including this byte
  assign len         = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : COUNT_MAX;
  assign payload_len = len - POS_PAYLOAD;
  assign inspected   = (len >= POS_PAYLOAD) && ethertype_ok_next &&
                       udp_protocol_ok_next && port_match_next;

  // Verdict, tested in priority order
  always_comb begin
    verdict.pass_frame     = 1'b1;
    verdict.verdict_reason = upf_pkg::REASON_NONE;
    if (inspected) begin
      priority if (len < POS_PAY_END) begin
        verdict.pass_frame     = 1'b0;
        verdict.verdict_reason = upf_pkg::REASON_TOO_SMALL;
      end else if (17'(payload_len) > 17'(cfg.max_payload_bytes)) begin
        verdict.pass_frame     = 1'b0;
        verdict.verdict_reason = upf_pkg::REASON_TOO_LARGE;
      end else if (fragment_seen_next) begin
        verdict.pass_frame     = 1'b0;
        verdict.verdict_reason = upf_pkg::REASON_FRAGMENT;
      end else if (!signature_ok_next) begin
        verdict.pass_frame     = 1'b0;
        verdict.verdict_reason = upf_pkg::REASON_SIGNATURE;
      end else begin
        verdict.pass_frame     = 1'b1;
        verdict.verdict_reason = upf_pkg::REASON_PASSED;
      end
    end
  end

  // Advance frame state; clear after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count      <= '0;
      ethertype_ok    <= 1'b1;
      udp_protocol_ok <= 1'b1;
      port_match      <= 1'b1;
      fragment_seen   <= 1'b0;
      signature_ok    <= 1'b1;
    end else if (step) begin
      byte_count      <= len;
      ethertype_ok    <= ethertype_ok_next;
      udp_protocol_ok <= udp_protocol_ok_next;
      port_match      <= port_match_next;
      fragment_seen   <= fragment_seen_next;
      signature_ok    <= signature_ok_next;
    end
  end

endmodule

[src/udp_payload_signature_filter_unit.sv]
// ----------------------------------------------------------------------------
// udp_payload_signature_filter_unit
// Streaming Ethernet frame filter with a pass/drop verdict per frame.
// ----------------------------------------------------------------------------
// Frame bytes enter one per clock on frame_in; a new byte is taken every cycle
// as long as verdicts are drained. Each byte is captured in an input register
// and checked against fixed header offsets while it is held. The verdict
// of a frame is formed from its held last byte and lands in the result
// register when that byte advances; a waiting verdict holds the last byte
// in the input register. Only the last byte of a frame produces a verdict
// transaction; while a verdict waits on verdict_out, bytes that are not a
// frame end still flow. IPv4 UDP frames to dest_port are checked for
// payload length (16 to max_payload_bytes), fragmentation and a fixed
// payload signature; all other frames pass with reason 0. The byte counter
// saturates at 2^COUNT_BITS - 1. The user must write registers through the
// APB port only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "udp_payload_signature_filter_unit_assert.svh"

module udp_payload_signature_filter_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  upf_in_if.sink      frame_in,
  upf_out_if.source   verdict_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  upf_pkg::upf_cfg_t     cfg;
  upf_pkg::upf_verdict_t verdict;

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  // Result register
  logic       res_valid;
  logic       res_pass;
  logic [2:0] res_reason;

  logic adv;

  upf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upf_inspect #(
    .COUNT_BITS (COUNT_BITS)
  ) u_inspect (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .frame_byte (hold_byte),
    .last_byte  (hold_last),
    .cfg        (cfg),
    .verdict    (verdict)
  );

  // Advance a held byte unless it is a frame end blocked by a waiting verdict
  assign adv            = hold_valid && (!hold_last || !res_valid || verdict_out.ready);
  assign frame_in.ready = !hold_valid || adv;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frame_in.ready) begin
      hold_valid <= frame_in.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (frame_in.ready && frame_in.valid) begin
      hold_byte <= frame_in.frame_byte;
      hold_last <= frame_in.last_byte;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && hold_last) begin
      res_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (adv && hold_last) begin
      res_pass   <= verdict.pass_frame;
      res_reason <= verdict.verdict_reason;
    end
  end

  assign verdict_out.valid          = res_valid;
  assign verdict_out.pass_frame     = res_pass;
  assign verdict_out.verdict_reason = res_reason;

  // A frame end that advances always produces a verdict
  `UPF_ASSERT_NXT(a_end_gives_verdict, clk, rst, adv && hold_last, res_valid,
                  "frame end advanced without a verdict")

  // A taken verdict is not repeated unless a new frame end advanced
  `UPF_ASSERT_NXT(a_no_repeat, clk, rst,
                  res_valid && verdict_out.ready && !(adv && hold_last), !res_valid,
                  "verdict repeated")

  // Pass flag agrees with the reason code
  `UPF_ASSERT_IMP(a_pass_matches_reason, clk, rst, res_valid,
                  res_pass == ((res_reason == upf_pkg::REASON_NONE) ||
                               (res_reason == upf_pkg::REASON_PASSED)),
                  "pass flag disagrees with reason")

  // Reason code stays within the defined set
  `UPF_ASSERT_IMP(a_reason_range, clk, rst, res_valid,
                  res_reason <= upf_pkg::REASON_SIGNATURE,
                  "undefined verdict reason")

endmodule

[sim/upf_verdict_checker.sv]
// ----------------------------------------------------------------------------
// upf_verdict_checker
// Watches the frame byte channel, the verdict channel and the register port
// of the UDP payload signature filter. Every accepted byte is run through a
// cycle-free model of the filter; each frame end queues the verdict it must
// produce, and every verdict transaction is compared field by field with
// the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upf_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  upf_in_if           frame_in,
  upf_out_if          verdict_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  localparam int          COUNT_BITS = 16;
  localparam int unsigned COUNT_SAT  = (1 << COUNT_BITS) - 1;

  // Register copy and per-frame tracking
  upf_pkg::upf_cfg_t     cfg;
  logic [COUNT_BITS-1:0] seen_bytes;
  logic                  ethertype_good;
  logic                  proto_good;
  logic                  port_good;
  logic                  frag_hit;
  logic                  sig_good;
  upf_pkg::upf_verdict_t verdict_q[$];
  int                    fail_count = 0;

  function automatic logic in_span(input logic [7:0] b, input logic [7:0] lo,
                                   input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  // Allowed values of payload byte k; bytes 0 and 4 are free
  function automatic logic payload_byte_fits(input int unsigned k, input logic [7:0] b);
    case (k)
      1:       return in_span(b, 8'h2A, 8'h2D);
      2:       return in_span(b, 8'hC8, 8'hE7);
      3:       return in_span(b, 8'h05, 8'h44);
      5:       return in_span(b, 8'h4E, 8'h51);
      6:       return in_span(b, 8'h60, 8'hDF);
      7:       return in_span(b, 8'h64, 8'hE3);
      8:       return (b == 8'h07) || (b == 8'h4F);
      9:       return (b == 8'h25) || (b == 8'h53);
      10:      return in_span(b, 8'h7C, 8'h83);
      11:      return in_span(b, 8'hAF, 8'hB6);
      12:      return in_span(b, 8'h21, 8'h60);
      13:      return (b == 8'h61) || (b == 8'h05) || (b == 8'h2B) || (b == 8'h0D);
      14:      return in_span(b, 8'hD2, 8'hF1);
      15:      return in_span(b, 8'h11, 8'h90);
      default: return 1'b1;
    endcase
  endfunction

  task automatic start_frame();
    seen_bytes     = '0;
    ethertype_good = 1'b1;
    proto_good     = 1'b1;
    port_good      = 1'b1;
    frag_hit       = 1'b0;
    sig_good       = 1'b1;
  endtask

  // Fold one byte into the frame state; queue the verdict on the frame end
  task automatic take_byte(input logic [7:0] b, input logic lst);
    int unsigned           pos;
    int unsigned           len;
    upf_pkg::upf_verdict_t v;
    pos = seen_bytes;
    case (pos)
      upf_pkg::OFS_ETHERTYPE_HI:
        if (b != upf_pkg::ETHERTYPE_HI) ethertype_good = 1'b0;
      upf_pkg::OFS_ETHERTYPE_LO:
        if (b != upf_pkg::ETHERTYPE_LO) ethertype_good = 1'b0;
      upf_pkg::OFS_FRAG_HI:
        if ((b & upf_pkg::FRAG_HI_MASK) != 8'h00) frag_hit = 1'b1;
      upf_pkg::OFS_FRAG_LO:
        if (b != 8'h00) frag_hit = 1'b1;
      upf_pkg::OFS_PROTOCOL:
        if (b != upf_pkg::PROTO_UDP) proto_good = 1'b0;
      upf_pkg::OFS_PORT_HI:
        if (b != cfg.dest_port[15:8]) port_good = 1'b0;
      upf_pkg::OFS_PORT_LO:
        if (b != cfg.dest_port[7:0]) port_good = 1'b0;
      default: ;
    endcase
    if (pos > upf_pkg::OFS_PAYLOAD &&
        pos < upf_pkg::OFS_PAYLOAD + upf_pkg::MIN_PAYLOAD &&
        !payload_byte_fits(pos - upf_pkg::OFS_PAYLOAD, b)) begin
      sig_good = 1'b0;
    end

    // Saturate the count: an overlong frame is judged at the ceiling
    len = (pos < COUNT_SAT) ? pos + 1 : COUNT_SAT;
    seen_bytes = len[COUNT_BITS-1:0];

    if (lst) begin
      v.pass_frame     = 1'b1;
      v.verdict_reason = upf_pkg::REASON_NONE;
      if (len >= upf_pkg::OFS_PAYLOAD && ethertype_good && proto_good && port_good) begin
        v.pass_frame = 1'b0;
        if (len < upf_pkg::OFS_PAYLOAD + upf_pkg::MIN_PAYLOAD) begin
          v.verdict_reason = upf_pkg::REASON_TOO_SMALL;
        end else if (len - upf_pkg::OFS_PAYLOAD > cfg.max_payload_bytes) begin
          v.verdict_reason = upf_pkg::REASON_TOO_LARGE;
        end else if (frag_hit) begin
          v.verdict_reason = upf_pkg::REASON_FRAGMENT;
        end else if (!sig_good) begin
          v.verdict_reason = upf_pkg::REASON_SIGNATURE;
        end else begin
          v.pass_frame     = 1'b1;
          v.verdict_reason = upf_pkg::REASON_PASSED;
        end
      end
      verdict_q.push_back(v);
      start_frame();
    end
  endtask

  always @(posedge clk) begin
    upf_pkg::upf_verdict_t want;
    if (rst) begin
      cfg.dest_port         = upf_pkg::DEST_PORT_RESET;
      cfg.max_payload_bytes = upf_pkg::MAX_PAYLOAD_RESET;
      start_frame();
      verdict_q.delete();
    end else begin
      // Compare the verdict transaction with the oldest expected one
      if (verdict_out.valid && verdict_out.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with none expected: expected nothing, got pass=%0b reason=%0d",
                   $time, verdict_out.pass_frame, verdict_out.verdict_reason);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict_out.pass_frame !== want.pass_frame) begin
            $display("%0t: pass_frame expected %0b, got %0b",
                     $time, want.pass_frame, verdict_out.pass_frame);
            fail_count++;
          end
          if (verdict_out.verdict_reason !== want.verdict_reason) begin
            $display("%0t: verdict_reason expected %0d, got %0d",
                     $time, want.verdict_reason, verdict_out.verdict_reason);
            fail_count++;
          end
        end
      end

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == upf_pkg::REG_DEST_PORT) cfg.dest_port = pwdata[15:0];
        else cfg.max_payload_bytes = pwdata[15:0];
      end

      if (frame_in.valid && frame_in.ready) begin
        take_byte(frame_in.frame_byte, frame_in.last_byte);
      end
    end
    pending    <= verdict_q.size();
    mismatches <= fail_count;
  end

endmodule

[sim/tb_udp_payload_signature_filter_unit.sv]
// ----------------------------------------------------------------------------
// tb_udp_payload_signature_filter_unit
// Stimulus and verdict for the UDP payload signature filter. Sends directed
// frames (length limits, fragment flags, header mismatches, signature
// failures, check priority), then random well-formed, truncated and noise
// frames under several register settings, with bursty byte delivery and a
// stalling verdict receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_udp_payload_signature_filter_unit;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HDR_BYTES   = upf_pkg::OFS_PAYLOAD + upf_pkg::MIN_PAYLOAD;
  localparam int NO_EDIT     = -1;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;

  upf_in_if  frame_in ();
  upf_out_if verdict_out ();

  // Stimulus bookkeeping
  logic [7:0]  frame_hdr [0:HDR_BYTES-1];
  logic [15:0] cur_port;
  int          cur_max;
  int          burst_left = 0;
  int          sent_bytes = 0;
  int          sent_frames = 0;

  always #2 clk = ~clk;

  udp_payload_signature_filter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .verdict_out(verdict_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  upf_verdict_checker verdict_check (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .verdict_out(verdict_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Pick a value in [lo, hi], favoring the two ends
  function automatic logic [7:0] pick_span(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // Payload byte k that satisfies the signature
  function automatic logic [7:0] signature_byte(input int k);
    logic [7:0] opts [4];
    opts = '{8'h61, 8'h05, 8'h2B, 8'h0D};
    case (k)
      1:       return pick_span(8'h2A, 8'h2D);
      2:       return pick_span(8'hC8, 8'hE7);
      3:       return pick_span(8'h05, 8'h44);
      5:       return pick_span(8'h4E, 8'h51);
      6:       return pick_span(8'h60, 8'hDF);
      7:       return pick_span(8'h64, 8'hE3);
      8:       return $urandom_range(0, 1) ? 8'h07 : 8'h4F;
      9:       return $urandom_range(0, 1) ? 8'h25 : 8'h53;
      10:      return pick_span(8'h7C, 8'h83);
      11:      return pick_span(8'hAF, 8'hB6);
      12:      return pick_span(8'h21, 8'h60);
      13:      return opts[$urandom_range(0, 3)];
      14:      return pick_span(8'hD2, 8'hF1);
      15:      return pick_span(8'h11, 8'h90);
      default: return 8'($urandom);
    endcase
  endfunction

  // Fill the header with an IPv4 UDP frame to the current port and a good signature
  task automatic build_udp_frame();
    for (int i = 0; i < HDR_BYTES; i++) frame_hdr[i] = 8'($urandom);
    frame_hdr[upf_pkg::OFS_ETHERTYPE_HI] = upf_pkg::ETHERTYPE_HI;
    frame_hdr[upf_pkg::OFS_ETHERTYPE_LO] = upf_pkg::ETHERTYPE_LO;
    frame_hdr[upf_pkg::OFS_FRAG_HI]      = $urandom_range(0, 1) ? 8'h40 : 8'h00;
    frame_hdr[upf_pkg::OFS_FRAG_LO]      = 8'h00;
    frame_hdr[upf_pkg::OFS_PROTOCOL]     = upf_pkg::PROTO_UDP;
    frame_hdr[upf_pkg::OFS_PORT_HI]      = cur_port[15:8];
    frame_hdr[upf_pkg::OFS_PORT_LO]      = cur_port[7:0];
    for (int k = 1; k < upf_pkg::MIN_PAYLOAD; k++) begin
      frame_hdr[upf_pkg::OFS_PAYLOAD + k] = signature_byte(k);
    end
  endtask

  // Offer one byte; return at the edge that accepts it
  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        frame_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    frame_in.valid      <= 1'b1;
    frame_in.frame_byte <= b;
    frame_in.last_byte  <= lst;
    do @(posedge clk); while (!frame_in.ready);
  endtask

  // Send len bytes: the header first, random filler past it
  task automatic send_frame(input int len);
    for (int pos = 0; pos < len; pos++) begin
      push_byte((pos < HDR_BYTES) ? frame_hdr[pos] : 8'($urandom), pos == len - 1);
    end
    sent_bytes += len;
    sent_frames++;
  endtask

  task automatic udp_case(input int len, input int ofs, input logic [7:0] val);
    build_udp_frame();
    if (ofs != NO_EDIT) frame_hdr[ofs] = val;
    send_frame(len);
  endtask

  // Hold the sender until every verdict is in, then let the pipe settle
  task automatic drain_verdicts();
    frame_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] port, input logic [15:0] maxp);
    drain_verdicts();
    write_reg(upf_pkg::REG_DEST_PORT, port);
    write_reg(upf_pkg::REG_MAX_PAYLOAD, maxp);
    cur_port = port;
    cur_max  = maxp;
  endtask

  // Mostly well-formed frames with random defects, plus truncated and noise frames
  task automatic random_frame();
    int kind;
    int plen;
    int len;
    int hdr_ofs [5];
    hdr_ofs = '{upf_pkg::OFS_ETHERTYPE_HI, upf_pkg::OFS_ETHERTYPE_LO,
                upf_pkg::OFS_PROTOCOL, upf_pkg::OFS_PORT_HI, upf_pkg::OFS_PORT_LO};
    kind = $urandom_range(0, 19);
    if (kind < 13) begin
      build_udp_frame();
      case ($urandom_range(0, 9))
        6, 7: begin
          if (cur_max <= 200) begin
            plen = cur_max + $urandom_range(0, 2) - 1;
            if (plen < 0) plen = 0;
          end else begin
            plen = $urandom_range(41, 200);
          end
        end
        8:       plen = $urandom_range(0, 15);
        9:       plen = $urandom_range(41, 200);
        default: plen = $urandom_range(16, 40);
      endcase
      len = upf_pkg::OFS_PAYLOAD + plen;
      if ($urandom_range(0, 4) == 0) begin
        frame_hdr[upf_pkg::OFS_FRAG_HI + $urandom_range(0, 1)] = 8'($urandom);
      end
      if ($urandom_range(0, 3) == 0) begin
        frame_hdr[upf_pkg::OFS_PAYLOAD + $urandom_range(1, 15)] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        frame_hdr[upf_pkg::OFS_PAYLOAD + $urandom_range(1, 15)] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        frame_hdr[hdr_ofs[$urandom_range(0, 4)]] = 8'($urandom);
      end
    end else if (kind < 16) begin
      build_udp_frame();
      len = $urandom_range(1, HDR_BYTES - 1);
    end else begin
      for (int i = 0; i < HDR_BYTES; i++) frame_hdr[i] = 8'($urandom);
      len = $urandom_range(1, 80);
    end
    send_frame(len);
  endtask

  // Send random frames until at least min_bytes have gone out
  task automatic random_phase(input int min_bytes);
    int bytes0;
    bytes0 = sent_bytes;
    while (sent_bytes - bytes0 < min_bytes) random_frame();
  endtask

  // Verdict receiver: stall on a random 8-bit mask, reloaded when stall_tick wraps
  initial begin
    logic [7:0] stall_mask;
    int         stall_tick;
    verdict_out.ready = 1'b0;
    stall_mask = 8'hFF;
    stall_tick = 0;
    forever begin
      @(posedge clk);
      if (stall_tick == 0) begin
        stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end
      verdict_out.ready <= stall_mask[3'(stall_tick % 8)];
      stall_tick = (stall_tick + 1) % 64;
    end
  end

  // Abort a hung run
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    frame_in.valid      = 1'b0;
    frame_in.frame_byte = 8'h00;
    frame_in.last_byte  = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cur_port            = upf_pkg::DEST_PORT_RESET;
    cur_max             = upf_pkg::MAX_PAYLOAD_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Length limits around the header and the minimum payload
    udp_case(HDR_BYTES, NO_EDIT, 8'h00);
    udp_case(HDR_BYTES - 1, NO_EDIT, 8'h00);
    udp_case(upf_pkg::OFS_PAYLOAD, NO_EDIT, 8'h00);
    udp_case(upf_pkg::OFS_PAYLOAD - 1, NO_EDIT, 8'h00);
    udp_case(1, NO_EDIT, 8'h00);

    // Fragment field: don't-fragment alone passes, any other bit drops
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_HI, 8'h40);
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_HI, 8'h20);
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_HI, 8'h80);
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_HI, 8'h01);
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_LO, 8'h01);
    udp_case(HDR_BYTES, upf_pkg::OFS_FRAG_LO, 8'h80);

    // Header mismatches leave the frame uninspected
    udp_case(upf_pkg::OFS_PAYLOAD, upf_pkg::OFS_ETHERTYPE_HI, 8'h86);
    udp_case(upf_pkg::OFS_PAYLOAD, upf_pkg::OFS_ETHERTYPE_LO, 8'h01);
    udp_case(upf_pkg::OFS_PAYLOAD, upf_pkg::OFS_PROTOCOL, 8'd6);
    udp_case(upf_pkg::OFS_PAYLOAD, upf_pkg::OFS_PORT_HI, cur_port[15:8] ^ 8'h01);
    udp_case(upf_pkg::OFS_PAYLOAD, upf_pkg::OFS_PORT_LO, cur_port[7:0] ^ 8'h80);

    // Signature failures just outside the allowed values
    udp_case(HDR_BYTES, upf_pkg::OFS_PAYLOAD + 1, 8'h29);
    udp_case(HDR_BYTES, upf_pkg::OFS_PAYLOAD + 15, 8'h91);
    udp_case(HDR_BYTES, upf_pkg::OFS_PAYLOAD + 13, 8'h00);

    // Check priority: size before fragment, fragment before signature
    udp_case(HDR_BYTES - 1, upf_pkg::OFS_FRAG_HI, 8'h20);
    build_udp_frame();
    frame_hdr[upf_pkg::OFS_FRAG_HI]     = 8'h20;
    frame_hdr[upf_pkg::OFS_PAYLOAD + 2] = 8'h00;
    send_frame(HDR_BYTES);

    // Constant byte frames
    for (int i = 0; i < HDR_BYTES; i++) frame_hdr[i] = 8'hFF;
    send_frame(upf_pkg::OFS_PAYLOAD);
    for (int i = 0; i < HDR_BYTES; i++) frame_hdr[i] = 8'h00;
    send_frame(upf_pkg::OFS_PAYLOAD);

    // Small payload limit: at the maximum, one over, and size before fragment
    set_config(16'($urandom), 16'd20);
    udp_case(upf_pkg::OFS_PAYLOAD + cur_max, NO_EDIT, 8'h00);
    udp_case(upf_pkg::OFS_PAYLOAD + cur_max + 1, NO_EDIT, 8'h00);
    udp_case(upf_pkg::OFS_PAYLOAD + cur_max + 1, upf_pkg::OFS_FRAG_LO, 8'h10);
    random_phase(40);

    // Random traffic under several register settings
    set_config(16'h0000, 16'h0000);
    random_phase(40);

    set_config(16'hFFFF, 16'hFFFF);
    random_phase(40);

    set_config(16'($urandom), 16'($urandom_range(16, 200)));
    random_phase(40);

    drain_verdicts();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/upf_pkg.sv
src/upf_in_if.sv
src/upf_out_if.sv
src/upf_cfg_regs.sv
src/upf_inspect.sv
src/udp_payload_signature_filter_unit.sv
sim/upf_verdict_checker.sv
sim/tb_udp_payload_signature_filter_unit.sv
